[rtl/core/rrts_pkg.sv]
// rrts_pkg: item types and codes for the round-robin thread scheduler
// no dependencies; used by round_robin_thread_scheduler
`default_nettype none

package rrts_pkg;

	// fixed field widths of the item ports
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned TICKS_W    = 16;
	localparam int unsigned MASK_W     = 8;
	localparam int unsigned TID_W      = 3;
	localparam int unsigned TIME_OUT_W = 32;

	// request codes
	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELAY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SCHED = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [TICKS_W-1:0] delay_ticks;
		logic [MASK_W-1:0]  disabled_mask;
	} req_t;

	typedef struct packed {
		logic [TID_W-1:0]      thread_id;
		logic                  switched;
		logic                  idle;
		logic [MASK_W-1:0]     ready_mask;
		logic [TIME_OUT_W-1:0] time_count;
	} rsp_t;

endpackage

`default_nettype wire

[rtl/core/round_robin_thread_scheduler.sv]
// round_robin_thread_scheduler: round-robin pick with per-thread delay timers
// depends on rrts_pkg for the item structs and request codes
//
//   channel   handshake              payload
//   req       req_valid/req_ready    rrts_pkg::req_t (mode, delay_ticks, disabled_mask)
//   rsp       rsp_valid/rsp_ready    rrts_pkg::rsp_t (thread_id, switched, idle, ...)
//
// one item per cycle sustained while rsp_ready is high; an accepted item is held in the
// input register, and its result is loaded into the result register once that is free
// the state update and the round-robin pick sit between those two registers
// reset clears the current thread, delay bits, time count and pending flag
// a stalled result register holds the input register, which then drops req_ready
`default_nettype none

module round_robin_thread_scheduler #(
	parameter int unsigned THREADS     = 8,
	parameter int unsigned DELAY_WIDTH = 16,
	parameter int unsigned TIME_WIDTH  = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire rrts_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output rrts_pkg::rsp_t     rsp
);

	localparam int unsigned MW = rrts_pkg::MASK_W;
	localparam int unsigned TW = rrts_pkg::TID_W;
	localparam logic [MW-1:0] THREAD_BITS = MW'((1 << THREADS) - 1);

	// input register
	logic           valid_s1;
	rrts_pkg::req_t req_s1;
	// result register
	logic           valid_s2;
	rrts_pkg::rsp_t rsp_s2;

	// scheduler state
	logic [TW-1:0]          cur_q;
	logic [MW-1:0]          delayed_q;
	logic [DELAY_WIDTH-1:0] cnt_q [THREADS];
	logic [TIME_WIDTH-1:0]  tick_q;
	logic                   pend_q;

	logic advance;

	// next state
	logic [MW-1:0]         nxt_delayed;
	logic [TIME_WIDTH-1:0] nxt_tick;
	logic [TW-1:0]         nxt_cur;
	logic                  nxt_pend;
	logic                  nxt_switched;
	logic                  try_sched;
	logic [MW-1:0]         ready_nxt;
	logic [TW-1:0]         pick_id;
	logic                  pick_found;
	logic [DELAY_WIDTH-1:0] dec [THREADS];
	logic [THREADS-1:0]    dec_zero;

	// handshake: result register frees the input register
	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	// per-thread countdown
	always_comb begin
		for (int i = 0; i < THREADS; i++) begin
			dec[i]      = cnt_q[i] - DELAY_WIDTH'(1);
			dec_zero[i] = (dec[i] == '0);
		end
	end

	// delay bits, time count and whether a pick is attempted
	always_comb begin
		nxt_delayed = delayed_q;
		nxt_tick    = tick_q;
		try_sched   = 1'b0;
		case (req_s1.mode)
			rrts_pkg::MODE_TICK: begin
				for (int i = 0; i < THREADS; i++) begin
					if (delayed_q[i] && dec_zero[i]) begin
						nxt_delayed[i] = 1'b0;
					end
				end
				nxt_tick  = tick_q + TIME_WIDTH'(1);
				try_sched = pend_q;
			end
			rrts_pkg::MODE_DELAY: begin
				nxt_delayed = delayed_q | ((MW'(1) << cur_q) & THREAD_BITS);
				try_sched   = 1'b1;
			end
			rrts_pkg::MODE_SCHED: begin
				try_sched = 1'b1;
			end
			default: begin
				try_sched = 1'b0;
			end
		endcase
		ready_nxt = ~(req_s1.disabled_mask | nxt_delayed) & THREAD_BITS;
	end

	// round-robin search from the thread after the current one
	always_comb begin
		logic [TW:0] sum;
		pick_id    = cur_q;
		pick_found = |ready_nxt;
		for (int n = THREADS; n >= 1; n--) begin
			sum = {1'b0, cur_q} + (TW+1)'(n);
			if (sum >= (TW+1)'(THREADS)) begin
				sum = sum - (TW+1)'(THREADS);
			end
			if (ready_nxt[sum[TW-1:0]]) begin
				pick_id = sum[TW-1:0];
			end
		end
	end

	// outcome of the pick
	always_comb begin
		nxt_cur      = cur_q;
		nxt_pend     = pend_q;
		nxt_switched = 1'b0;
		if (try_sched) begin
			if (pick_found) begin
				nxt_cur      = pick_id;
				nxt_pend     = 1'b0;
				nxt_switched = 1'b1;
			end else begin
				nxt_pend = 1'b1;
			end
		end
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			cur_q     <= '0;
			delayed_q <= '0;
			tick_q    <= '0;
			pend_q    <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2  <= 1'b1;
				cur_q     <= nxt_cur;
				delayed_q <= nxt_delayed;
				tick_q    <= nxt_tick;
				pend_q    <= nxt_pend;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_s2.thread_id  <= nxt_cur;
			rsp_s2.switched   <= nxt_switched;
			rsp_s2.idle       <= nxt_pend;
			rsp_s2.ready_mask <= ready_nxt;
			rsp_s2.time_count <= rrts_pkg::TIME_OUT_W'(nxt_tick);
		end
	end

	// delay counters: load on delay request, count down on tick
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < THREADS; i++) begin
				if (req_s1.mode == rrts_pkg::MODE_TICK && delayed_q[i]) begin
					cnt_q[i] <= dec[i];
				end else if (req_s1.mode == rrts_pkg::MODE_DELAY && cur_q == TW'(i)) begin
					cnt_q[i] <= DELAY_WIDTH'(req_s1.delay_ticks);
				end
			end
		end
	end

`ifndef SYNTHESIS
	// no delay bit outside the configured threads
	assert property (@(posedge clk) disable iff (!arst_n)
		(delayed_q & ~THREAD_BITS) == '0)
		else $error("delay bit set beyond thread count");

	// current thread stays in range
	assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cur_q} < (TW+1)'(THREADS))
		else $error("current thread out of range");

	// a completed pick is never reported idle, and the chosen thread is ready
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.switched |-> !rsp.idle && rsp.ready_mask[rsp.thread_id])
		else $error("switched result inconsistent");

	// a tick advances the time count by one
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.mode == rrts_pkg::MODE_TICK
		|=> tick_q == $past(tick_q) + TIME_WIDTH'(1))
		else $error("time count did not advance on tick");

	// input is only held off by a full input register behind a stalled result register
	assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> valid_s1 && valid_s2 && !rsp_ready)
		else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire
